### rtl/gost_block_encrypt_unit_defines.svh
// assertion macros used by the checker file
`ifndef GOST_BLOCK_ENCRYPT_UNIT_DEFINES_SVH
`define GOST_BLOCK_ENCRYPT_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GBE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gbe_pkg.sv
// shared types, constants and s-box table of the gost block encrypt unit
package gbe_pkg;

    localparam int BLOCK_W     = 64;
    localparam int HALF_W      = 32;
    localparam int KEY_WORDS   = 8;
    localparam int KEY_SEL_W   = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int ROUNDS      = 32;
    localparam int ROUND_W     = 5;
    localparam int REV_START   = 24;
    localparam int ROT_LEFT    = 11;
    localparam int NIBBLES     = 8;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    // test s-boxes, row n serves nibble n counted from the lowest
    localparam logic [3:0] SBOX [0:NIBBLES-1][0:15] = '{
        '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
          4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
        '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
          4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
        '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
          4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
        '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
          4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
        '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
          4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
        '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
          4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
        '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
          4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
        '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
          4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
    };

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic               load;      // take a new block into the halves
        logic               round_en;  // run one feistel round
        logic [ROUND_W-1:0] round;     // current round number
        logic               out_load;  // copy result into the output register
    } dp_cmd_t;

endpackage

### rtl/gost_block_encrypt_unit.sv
// top level of the gost 28147-89 ecb block encrypt unit
//
// channel  direction  handshake            payload
// s_*      in         s_tvalid / s_tready  s_tdata  [63:0] plain_block
// m_*      out        m_tvalid / m_tready  m_tdata  [63:0] cipher_block
// cfg_*    in         cfg_we               cfg_index [3:0], cfg_data [31:0]
//
// a block is accepted, runs through 32 rounds, then is handed over
// the rounds run one per cycle through the single shared round function
// the output register lets a new block enter while the last result waits
// a held result stalls only the hand-over cycle of the following block
// reset clears the key words to zero and the control state; no clearing pass
module gost_block_encrypt_unit
    import gbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave side
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BLOCK_W-1:0]   s_tdata,   // [63:0] plain_block
    // master side
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [BLOCK_W-1:0]   m_tdata,   // [63:0] cipher_block
    // key word writes, index 8 and above are dropped
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_data
);

    dp_cmd_t cmd;

    // sequencing of accept, rounds and output transaction
    gbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // key store, feistel halves and result register
    gbe_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cmd       (cmd)
    );

endmodule

### rtl/gbe_ctrl.sv
// controller state machine: round sequencing and output handoff
module gbe_ctrl
    import gbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    state_t             state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next   = state_reg;
        round_next   = round_reg;
        cmd.load     = 1'b0;
        cmd.round_en = 1'b0;
        cmd.out_load = 1'b0;
        cmd.round    = round_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    round_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + ROUND_W'(1);
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

### rtl/gbe_datapath.sv
// datapath: key registers, feistel halves, round function, output register
module gbe_datapath
    import gbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]    cfg_data,
    input  logic [BLOCK_W-1:0]   s_tdata,
    output logic [BLOCK_W-1:0]   m_tdata,
    input  dp_cmd_t              cmd
);

    // a feeds the round function, b takes the xor
    logic [HALF_W-1:0]  key_reg [KEY_WORDS];
    logic [HALF_W-1:0]  a_reg, a_next;
    logic [HALF_W-1:0]  b_reg, b_next;
    logic [BLOCK_W-1:0] out_reg;
    logic [KEY_SEL_W-1:0] key_sel;
    logic [HALF_W-1:0]  sum;
    logic [HALF_W-1:0]  subst;
    logic [HALF_W-1:0]  f_out;

    // forward key order for the first three passes, reversed for the last
    assign key_sel = (cmd.round < ROUND_W'(REV_START)) ? cmd.round[KEY_SEL_W-1:0]
                                                       : ~cmd.round[KEY_SEL_W-1:0];

    assign sum = a_reg + key_reg[key_sel];

    always_comb
    begin
        for (int n = 0; n < NIBBLES; n++)
        begin
            subst[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
        end
    end

    assign f_out = {subst[HALF_W-ROT_LEFT-1:0], subst[HALF_W-1:HALF_W-ROT_LEFT]};

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        if (cmd.load)
        begin
            a_next = s_tdata[BLOCK_W-1:HALF_W];
            b_next = s_tdata[HALF_W-1:0];
        end
        else if (cmd.round_en)
        begin
            a_next = b_reg ^ f_out;
            b_next = a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < CFG_IDX_W'(KEY_WORDS)))
        begin
            key_reg[cfg_index[KEY_SEL_W-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        if (cmd.out_load)
        begin
            // halves leave exchanged: last low half on top
            out_reg <= {b_reg, a_reg};
        end
    end

    assign m_tdata = out_reg;

endmodule

### rtl/gbe_checker.sv
// port-level checker of the gost block encrypt unit and its bind
`include "gost_block_encrypt_unit_defines.svh"

module gbe_checker
    import gbe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [BLOCK_W-1:0] m_tdata
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // a stalled result keeps its value
    `GBE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

    // one block at a time: no accept right after an accept
    `GBE_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_tready, "input accepted while busy")

    // still busy in the last round cycle
    `GBE_ASSERT_NEXT(a_busy_rounds, s_acc, ##31 !s_tready, "round sequence cut short")

    // a new result appears only at the hand-over, never while idle
    `GBE_ASSERT_NOW(a_result_from_run, $rose(m_tvalid), $past(!s_tready), "result without a block")

endmodule

bind gost_block_encrypt_unit gbe_checker u_chk (.*);

### tb/tb_gost_block_encrypt_unit.sv
// self-checking testbench for the gost 28147-89 ecb block encrypt unit
`timescale 1ns / 100ps

module tb_gost_block_encrypt_unit;
    import gbe_pkg::*;

    // generous ceiling on the length of the whole run, in cycles
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BLOCKS  = 102;
    localparam int LONG_HOLD     = 300;

    typedef enum
    {
        KEY_ZERO,
        KEY_ONES,
        KEY_RAMP,
        KEY_MIXED
    } key_style_t;

    // one outstanding ciphertext, with its plaintext kept for the report
    typedef struct
    {
        logic [BLOCK_W-1:0] plain;
        logic [BLOCK_W-1:0] cipher;
    } cipher_entry_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BLOCK_W-1:0]   s_tdata;     // [63:0] plain_block
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BLOCK_W-1:0]   m_tdata;     // [63:0] cipher_block
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HALF_W-1:0]    cfg_data;

    // private copy of the key registers, updated on every accepted write
    logic [HALF_W-1:0] key_words [KEY_WORDS];
    cipher_entry_t     pending_ciphers [$];

    int cycle_count;
    int error_count;
    int blocks_sent;
    int blocks_checked;
    int key_loads;
    int input_stall_cycles;
    int stall_pct;
    int ready_hold_cycles;

    gost_block_encrypt_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // key schedule: three forward passes over the words, then one backward
    function automatic int subkey_sel(input int rnd);
        return (rnd < REV_START) ? (rnd % KEY_WORDS) : (ROUNDS - 1 - rnd);
    endfunction

    // modular add, one s-box per nibble, then rotate left by eleven
    function automatic logic [HALF_W-1:0] gost_round(input logic [HALF_W-1:0] half,
                                                     input logic [HALF_W-1:0] subkey);
        logic [HALF_W-1:0] sum;
        logic [HALF_W-1:0] subst;
        sum = half + subkey;
        for (int n = 0; n < NIBBLES; n++)
            subst[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
        return {subst[HALF_W-1-ROT_LEFT:0], subst[HALF_W-1:HALF_W-ROT_LEFT]};
    endfunction

    function automatic logic [BLOCK_W-1:0] encrypt_block(input logic [BLOCK_W-1:0] plain);
        logic [HALF_W-1:0] n1;
        logic [HALF_W-1:0] n2;
        n1 = plain[HALF_W-1:0];
        n2 = plain[BLOCK_W-1:HALF_W];
        // rounds taken in pairs: n1 is updated first, then n2 from the new n1
        for (int r = 0; r < ROUNDS; r += 2)
        begin
            n1 ^= gost_round(n2, key_words[subkey_sel(r)]);
            n2 ^= gost_round(n1, key_words[subkey_sel(r + 1)]);
        end
        // halves exchanged after the last round
        return {n1, n2};
    endfunction

    // half word biased towards the extremes
    function automatic logic [HALF_W-1:0] rand_half();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // cycle counter, timeout and input stall monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (s_tvalid && !s_tready && rst_n)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_ciphers.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall runs, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (ready_hold_cycles > 0)
        begin
            m_tready          <= 1'b0;
            ready_hold_cycles <= ready_hold_cycles - 1;
        end
        else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        begin
            m_tready          <= 1'b0;
            ready_hold_cycles <= $urandom_range(0, 11);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checker: each output transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cipher_entry_t head;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_ciphers.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected cipher_block, expected none, got %h",
                         $time, m_tdata);
            end
            else
            begin
                head = pending_ciphers.pop_front();
                blocks_checked++;
                if (m_tdata !== head.cipher)
                begin
                    error_count++;
                    $display("%0t: cipher_block mismatch for plain %h, expected %h, got %h",
                             $time, head.plain, head.cipher, m_tdata);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driver tasks, all entered and left at a falling edge
    // ------------------------------------------------------------------

    // one input transaction; valid stays up when another block follows at once
    task automatic send_block(input logic [BLOCK_W-1:0] blk, input bit hold_valid);
        cipher_entry_t entry;
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        entry.plain  = blk;
        entry.cipher = encrypt_block(blk);
        pending_ciphers = {pending_ciphers, entry};
        blocks_sent++;
        @(negedge clk);
        if (!hold_valid)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // sender pauses until every outstanding result has been handed over
    task automatic drain();
        while (pending_ciphers.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one register write, after which the enable goes low again
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HALF_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx < KEY_WORDS)
            key_words[idx[KEY_SEL_W-1:0]] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // full key reload, only once the unit has gone idle
    task automatic load_key(input key_style_t style);
        logic [HALF_W-1:0] word;
        drain();
        for (int i = 0; i < KEY_WORDS; i++)
        begin
            case (style)
                KEY_ZERO: word = 32'h0000_0000;
                KEY_ONES: word = 32'hFFFF_FFFF;
                KEY_RAMP: word = 32'h0101_0101 * (i + 1);
                default:  word = rand_half();
            endcase
            write_reg(CFG_IDX_W'(i), word);
        end
        key_loads++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // all-zero key with the extreme and alternating plaintexts
    task automatic test_zero_key();
        stall_pct = 0;
        load_key(KEY_ZERO);
        send_block(64'h0000_0000_0000_0000, 1'b0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_block(64'hFFFF_FFFF_0000_0000, 1'b0);
        send_block(64'h0000_0000_FFFF_FFFF, 1'b0);
        send_block(64'h5555_5555_5555_5555, 1'b1);
        send_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    endtask

    // all-ones key wraps the modular add; a ramp key exposes the word order
    task automatic test_key_extremes();
        stall_pct = 25;
        load_key(KEY_ONES);
        send_block(64'h0000_0000_0000_0000, 1'b1);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_block(64'h0123_4567_89AB_CDEF, 1'b0);
        load_key(KEY_RAMP);
        send_block(64'h0123_4567_89AB_CDEF, 1'b0);
        send_block(64'hFEDC_BA98_7654_3210, 1'b0);
        send_block(64'h8000_0000_0000_0001, 1'b0);
    endtask

    // writes beyond the last key word must leave the key alone
    task automatic test_ignored_index();
        drain();
        for (int idx = KEY_WORDS; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), $urandom());
        send_block(64'h0123_4567_89AB_CDEF, 1'b0);
        send_block({rand_half(), rand_half()}, 1'b0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    endtask

    // receiver holds off for a long stretch while blocks keep coming
    task automatic test_backpressure();
        stall_pct = 0;
        drain();
        @(posedge clk);
        ready_hold_cycles = LONG_HOLD;
        @(negedge clk);
        for (int i = 0; i < 14; i++)
            send_block({rand_half(), rand_half()}, i != 13);
        drain();
    endtask

    // random keys (all-ones in the second phase) and plaintexts in bursts, with a fresh idling mix per phase
    task automatic test_random_traffic();
        int max_gap;
        int burst_left;
        int gap;
        bit last;
        bit burst_end;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_key(phase == 1 ? KEY_ONES : KEY_MIXED);
            // first phase runs with no idling on either side
            stall_pct  = (phase == 0) ? 0 : $urandom_range(5, 60);
            max_gap    = (phase == 0) ? 0 : $urandom_range(2, 40);
            burst_left = $urandom_range(1, 8);
            for (int i = 0; i < PHASE_BLOCKS; i++)
            begin
                last      = (i == PHASE_BLOCKS - 1);
                burst_left--;
                burst_end = (max_gap > 0) && (burst_left == 0);
                send_block({rand_half(), rand_half()}, !(last || burst_end));
                if (burst_end && !last)
                begin
                    gap = $urandom_range(1, max_gap);
                    repeat (gap - 1) @(negedge clk);
                    burst_left = $urandom_range(1, 8);
                end
            end
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        m_tready           = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        cycle_count        = 0;
        error_count        = 0;
        blocks_sent        = 0;
        blocks_checked     = 0;
        key_loads          = 0;
        input_stall_cycles = 0;
        stall_pct          = 0;
        ready_hold_cycles  = 0;
        // key registers come out of reset as zero
        for (int i = 0; i < KEY_WORDS; i++)
            key_words[i] = '0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_zero_key();
        test_key_extremes();
        test_ignored_index();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (40) @(negedge clk);

        $display("run covered %0d blocks under %0d key loads, %0d results checked",
                 blocks_sent, key_loads, blocks_checked);
        $display("input held off for %0d cycles by back-pressure, %0d errors",
                 input_stall_cycles, error_count);
        if (error_count == 0 && pending_ciphers.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/gbe_pkg.sv
rtl/gbe_ctrl.sv
rtl/gbe_datapath.sv
rtl/gost_block_encrypt_unit.sv
rtl/gbe_checker.sv
tb/tb_gost_block_encrypt_unit.sv
